@@ hw/rtl/lbd_pkg.sv @@
// Shared types, defaults and register indexes for the 3D label boundary marker.
package lbd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned LABEL_BITS_DEF = 16;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VOL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_DEPTH  = 2'd2;

  typedef struct packed {
    logic [15:0] voxel_label;
    logic        flush;
  } in_item_t;

  typedef struct packed {
    logic        is_boundary;
    logic [15:0] centre_label;
    logic        last_voxel;
  } out_item_t;

  // position of the centre voxel against the volume faces
  typedef struct packed {
    logic x_first;
    logic x_last;
    logic y_first;
    logic y_last;
    logic z_first;
    logic z_last;
  } bnd_flags_t;

endpackage

@@ hw/rtl/label_boundary_3d_26n.sv @@
// Top level: streaming 26-neighbour boundary marker for 3D label volumes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | input     | in_valid/in_stall  | voxel_label, flush
//   out     | output    | out_valid/out_stall| is_boundary, centre_label, last
//   cfg     | input     | cfg_we             | index, data (no read-back)
//
// One voxel per cycle sustained while the output is not stalled; each delay
// RAM does one read and one write per transaction. Nine window taps come from
// an input register, two plane delays and six row delays, the other two columns
// from shift registers. Reset clears pointers, counters, valid flags and the
// volume size registers; history RAM contents are never cleared. A stall on
// the output backs up into the input only when both result stages are full.
module label_boundary_3d_26n #(
  parameter int unsigned MAX_WIDTH  = lbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lbd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned LABEL_BITS = lbd_pkg::LABEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lbd_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lbd_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned LB     = LABEL_BITS;
  localparam int unsigned WB     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned PB     = $clog2(PDEPTH + 1);
  localparam int unsigned CB     = $clog2(PDEPTH + MAX_WIDTH + 2);

  // configuration
  logic [8:0]  w_q, h_q;
  logic [15:0] d_q;
  logic        restart;

  assign restart = cfg_we_i && ((cfg_idx_i == lbd_pkg::CFG_VOL_WIDTH) ||
                                (cfg_idx_i == lbd_pkg::CFG_VOL_HEIGHT) ||
                                (cfg_idx_i == lbd_pkg::CFG_VOL_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= 9'd256;
      h_q <= 9'd256;
      d_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbd_pkg::CFG_VOL_WIDTH:  w_q <= cfg_data_i[8:0];
        lbd_pkg::CFG_VOL_HEIGHT: h_q <= cfg_data_i[8:0];
        lbd_pkg::CFG_VOL_DEPTH:  d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WB-1:0] eff_w, eff_w_m1;
  logic [HB-1:0] eff_h;
  logic [15:0]   eff_d;
  logic [PB-1:0] plane, plane_m1;
  logic [CB-1:0] lag;

  always_comb begin
    if (w_q == '0)                  eff_w = WB'(1);
    else if (int'(w_q) > MAX_WIDTH) eff_w = WB'(MAX_WIDTH);
    else                            eff_w = WB'(w_q);
    if (h_q == '0)                   eff_h = HB'(1);
    else if (int'(h_q) > MAX_HEIGHT) eff_h = HB'(MAX_HEIGHT);
    else                             eff_h = HB'(h_q);
    eff_d = (d_q == '0) ? 16'd1 : d_q;
  end

  assign plane    = PB'(eff_w * eff_h);
  assign plane_m1 = plane - PB'(1);
  assign eff_w_m1 = eff_w - WB'(1);
  assign lag      = CB'(plane) + CB'(eff_w) + CB'(1);

  // handshake
  logic out_vld_q, win_vld_q;
  logic out_load, win_move, adv;

  assign out_load   = !out_vld_q || !out_stall_i;
  assign win_move   = win_vld_q && out_load;
  assign in_stall_o = win_vld_q && !out_load;
  assign adv        = in_valid_i && !in_stall_o;

  logic [LB-1:0] lab;
  assign lab = in_data_i.flush ? '0 : LB'(in_data_i.voxel_label);

  // window taps: tap[a][b] = x(t - a*plane - b*width)
  logic [LB-1:0] tap   [3][3];
  logic [LB-1:0] sh1_q [3][3];
  logic [LB-1:0] sh2_q [3][3];
  logic [LB-1:0] cur_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cur_q <= lab;
      sh1_q <= tap;
      sh2_q <= sh1_q;
    end
  end

  assign tap[0][0] = cur_q;

  lbd_delay_ram #(.DEPTH(MAX_WIDTH), .LB(LB)) u_row01 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(eff_w), .din_i(lab), .dout_o(tap[0][1]));
  lbd_delay_ram #(.DEPTH(MAX_WIDTH), .LB(LB)) u_row02 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(eff_w_m1), .din_i(tap[0][1]), .dout_o(tap[0][2]));
  lbd_delay_ram #(.DEPTH(PDEPTH), .LB(LB)) u_pl10 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(plane), .din_i(lab), .dout_o(tap[1][0]));
  lbd_delay_ram #(.DEPTH(MAX_WIDTH), .LB(LB)) u_row11 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(eff_w_m1), .din_i(tap[1][0]), .dout_o(tap[1][1]));
  lbd_delay_ram #(.DEPTH(MAX_WIDTH), .LB(LB)) u_row12 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(eff_w_m1), .din_i(tap[1][1]), .dout_o(tap[1][2]));
  lbd_delay_ram #(.DEPTH(PDEPTH), .LB(LB)) u_pl20 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(plane_m1), .din_i(tap[1][0]), .dout_o(tap[2][0]));
  lbd_delay_ram #(.DEPTH(MAX_WIDTH), .LB(LB)) u_row21 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(eff_w_m1), .din_i(tap[2][0]), .dout_o(tap[2][1]));
  lbd_delay_ram #(.DEPTH(MAX_WIDTH), .LB(LB)) u_row22 (
    .clk_i, .rst_ni, .adv_i(adv), .clr_i(restart),
    .len_i(eff_w_m1), .din_i(tap[2][1]), .dout_o(tap[2][2]));

  logic [LB-1:0] win [3][3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        win[a][b][0] = tap[a][b];
        win[a][b][1] = sh1_q[a][b];
        win[a][b][2] = sh2_q[a][b];
      end
    end
  end

  // stream position of the centre voxel
  logic [CB-1:0] cnt_q, cnt_d;
  logic [WB-1:0] col_q, col_d;
  logic [HB-1:0] row_q, row_d;
  logic [15:0]   pln_q, pln_d;
  logic          emit, col_last, row_last, pln_last, last;
  lbd_pkg::bnd_flags_t flags, win_flags_q;
  logic          win_last_q, win_vld_d;

  assign emit     = cnt_q >= lag;
  assign col_last = ((WB+1)'(col_q) + (WB+1)'(1)) >= (WB+1)'(eff_w);
  assign row_last = ((HB+1)'(row_q) + (HB+1)'(1)) >= (HB+1)'(eff_h);
  assign pln_last = (17'(pln_q) + 17'd1) >= 17'(eff_d);
  assign last     = col_last && row_last && pln_last;

  always_comb begin
    flags.x_first = (col_q == '0);
    flags.x_last  = col_last;
    flags.y_first = (row_q == '0);
    flags.y_last  = row_last;
    flags.z_first = (pln_q == '0);
    flags.z_last  = pln_last;
  end

  always_comb begin
    cnt_d = cnt_q;
    col_d = col_q;
    row_d = row_q;
    pln_d = pln_q;
    win_vld_d = win_vld_q;
    if (win_move) win_vld_d = 1'b0;
    priority if (restart) begin
      cnt_d = '0;
      col_d = '0;
      row_d = '0;
      pln_d = '0;
    end else if (adv) begin
      win_vld_d = emit;
      if (!emit) begin
        cnt_d = cnt_q + CB'(1);
      end else if (last) begin
        cnt_d = '0;
        col_d = '0;
        row_d = '0;
        pln_d = '0;
      end else if (col_last) begin
        col_d = '0;
        if (row_last) begin
          row_d = '0;
          pln_d = pln_q + 16'd1;
        end else begin
          row_d = row_q + HB'(1);
        end
      end else begin
        col_d = col_q + WB'(1);
      end
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      pln_q     <= '0;
      win_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      pln_q     <= pln_d;
      win_vld_q <= win_vld_d;
      if (out_load) out_vld_q <= win_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      win_flags_q <= flags;
      win_last_q  <= last;
    end
  end

  logic               is_bnd;
  lbd_pkg::out_item_t out_q;

  lbd_compare #(.LB(LB)) u_compare (
    .win_i(win), .flags_i(win_flags_q), .is_boundary_o(is_bnd));

  always_ff @(posedge clk_i) begin
    if (win_move) begin
      out_q.is_boundary  <= is_bnd;
      out_q.centre_label <= 16'(sh1_q[1][1]);
      out_q.last_voxel   <= win_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/lbd_delay_ram.sv @@
// Programmable-length delay line built on a one-port-read, one-port-write RAM.
module lbd_delay_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned LB    = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          clr_i,
  input  logic [LW-1:0] len_i,
  input  logic [LB-1:0] din_i,
  output logic [LB-1:0] dout_o
);

  logic [LB-1:0] mem_q [DEPTH];
  logic [LB-1:0] rd_q;
  logic [LB-1:0] byp_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [LW:0]   ptr_nxt;

  assign ptr_nxt = (LW+1)'(ptr_q) + (LW+1)'(1);

  always_comb begin
    ptr_d = ptr_q;
    if (clr_i) begin
      ptr_d = '0;
    end else if (adv_i) begin
      ptr_d = (ptr_nxt >= (LW+1)'(len_i)) ? '0 : AW'(ptr_nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // read-before-write: the slot holds the sample from len_i transactions ago
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mem_q[ptr_q] <= din_i;
      rd_q         <= mem_q[ptr_q];
      byp_q        <= din_i;
    end
  end

  assign dout_o = (len_i == '0) ? byp_q : rd_q;

endmodule

@@ hw/rtl/lbd_compare.sv @@
// 26-neighbour comparison of the centre voxel with face masking.
module lbd_compare #(
  parameter int unsigned LB = 16
) (
  input  logic [LB-1:0]       win_i [3][3][3],
  input  lbd_pkg::bnd_flags_t flags_i,
  output logic                is_boundary_o
);

  // win_i[a][b][c] holds the neighbour at dz = 1-a, dy = 1-b, dx = 1-c
  always_comb begin : cmp
    logic          ok;
    logic [LB-1:0] nl;
    logic          hit;
    hit = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 3; c++) begin
          ok = !((a == 2) && flags_i.z_first) && !((a == 0) && flags_i.z_last) &&
               !((b == 2) && flags_i.y_first) && !((b == 0) && flags_i.y_last) &&
               !((c == 2) && flags_i.x_first) && !((c == 0) && flags_i.x_last);
          nl = ok ? win_i[a][b][c] : '0;
          if (!((a == 1) && (b == 1) && (c == 1)) && (nl != win_i[1][1][1])) begin
            hit = 1'b1;
          end
        end
      end
    end
    is_boundary_o = hit && (win_i[1][1][1] != '0);
  end

endmodule

@@ hw/rtl/lbd_checker.sv @@
// Port-level checks for the boundary marker, bound to the top level.
module lbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lbd_pkg::out_item_t out_data_o
);

  // input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // background voxels are never boundary
  a_bg_not_bnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_boundary && (out_data_o.centre_label == '0)))
    else $error("background voxel flagged as boundary");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("result changed while stalled");

endmodule

bind label_boundary_3d_26n lbd_checker u_lbd_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o);
